// ===== sv/lstm_cell_state_update_int16_core_macros.svh =====
// Assertion macros for the LSTM cell state update core.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef LSTM_CELL_STATE_UPDATE_INT16_CORE_MACROS_SVH
`define LSTM_CELL_STATE_UPDATE_INT16_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define LCSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LCSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ===== sv/lcsu_pkg.sv =====
// Package for the LSTM cell state update core: widths, register indexes,
// requantization helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcsu_pkg;

    localparam int SUM_PRESHIFT   = 20;
    localparam int WIDE_W         = 104;
    localparam int SPLIT_W        = 35;
    localparam int SAT_MAX        = 32767;
    localparam int SAT_MIN        = -32768;

    localparam logic [2:0] REG_C_ZP      = 3'd0;
    localparam logic [2:0] REG_CNEW_ZP   = 3'd1;
    localparam logic [2:0] REG_CF_SCALE  = 3'd2;
    localparam logic [2:0] REG_IG_SCALE  = 3'd3;
    localparam logic [2:0] REG_ADD_FIRST = 3'd4;
    localparam logic [2:0] REG_ADD_SECOND = 3'd5;
    localparam logic [2:0] REG_ADD_RESULT = 3'd6;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [37:0] t_scale;

    function automatic logic [5:0] shift_amt(input t_scale scale);
        return 6'd31 - scale[37:32];
    endfunction

    function automatic logic signed [31:0] mult_of(input t_scale scale);
        return $signed(scale[31:0]);
    endfunction

    // round half up, then arithmetic shift right
    function automatic t_wide rnd_shift(input t_wide p, input logic [5:0] t);
        t_wide rnd;
        rnd = '0;
        if (t != 6'd0) begin
            rnd = t_wide'(1) <<< (t - 6'd1);
        end
        return (p + rnd) >>> t;
    endfunction

    // offset by zero point, saturate to int16
    function automatic logic signed [15:0] sat_ofs(input t_wide v,
                                                   input logic signed [15:0] zp);
        t_wide s;
        s = v + t_wide'(zp);
        if (s > t_wide'(SAT_MAX)) begin
            return 16'(SAT_MAX);
        end else if (s < t_wide'(SAT_MIN)) begin
            return 16'(SAT_MIN);
        end
        return 16'(s);
    endfunction

endpackage

`default_nettype wire

// ===== sv/lstm_cell_state_update_int16_core.sv =====
// LSTM int16 cell state update: nine-stage requantization pipeline.
// Depends on lcsu_pkg and lstm_cell_state_update_int16_core_macros.svh.
// Throughput: one item per cycle.
// busy stays low; the receiver takes each result in its strobe cycle.
// The widest product, sum times result multiplier, is split in two 35-bit halves.
// Synchronous reset clears the stage valid bits and all config registers to 0.
`timescale 1ns / 1ps
`default_nettype none

`include "lstm_cell_state_update_int16_core_macros.svh"

module lstm_cell_state_update_int16_core
    import lcsu_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire signed [15:0]  i_c_old,
    input  wire signed [7:0]   i_forget_gate,
    input  wire signed [7:0]   i_input_gate,
    input  wire signed [7:0]   i_cand_gate,
    output logic               o_c_new_valid,
    output logic signed [15:0] o_c_new,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [5:0]         paddr,
    input  wire  [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic signed [15:0] r_c_zp;
    logic signed [15:0] r_cnew_zp;
    t_scale             r_cf_scale;
    t_scale             r_ig_scale;
    t_scale             r_add_first;
    t_scale             r_add_second;
    t_scale             r_add_result;

    logic               cfg_wr;
    logic               s_acc;
    logic [8:0]         r_vld;

    logic signed [25:0] r1_cf,  n1_cf;
    logic signed [16:0] r1_ig,  n1_ig;
    logic signed [57:0] r2_cf,  n2_cf;
    logic signed [48:0] r2_ig,  n2_ig;
    logic signed [15:0] r3_cf,  n3_cf;
    logic signed [15:0] r3_ig,  n3_ig;
    logic signed [48:0] r4_a,   n4_a;
    logic signed [48:0] r4_b,   n4_b;
    logic signed [68:0] r5_ra,  n5_ra;
    logic signed [68:0] r5_rb,  n5_rb;
    logic signed [69:0] r6_sum, n6_sum;
    logic signed [67:0] r7_lo,  n7_lo;
    logic signed [66:0] r7_hi,  n7_hi;
    t_wide              r8_p,   n8_p;
    logic signed [15:0] r9_c_new, n9_c_new;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign s_acc  = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_zp       <= '0;
            r_cnew_zp    <= '0;
            r_cf_scale   <= '0;
            r_ig_scale   <= '0;
            r_add_first  <= '0;
            r_add_second <= '0;
            r_add_result <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_C_ZP:       r_c_zp       <= $signed(pwdata[15:0]);
                REG_CNEW_ZP:    r_cnew_zp    <= $signed(pwdata[15:0]);
                REG_CF_SCALE:   r_cf_scale   <= pwdata[37:0];
                REG_IG_SCALE:   r_ig_scale   <= pwdata[37:0];
                REG_ADD_FIRST:  r_add_first  <= pwdata[37:0];
                REG_ADD_SECOND: r_add_second <= pwdata[37:0];
                REG_ADD_RESULT: r_add_result <= pwdata[37:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_C_ZP:       prdata = {48'd0, r_c_zp};
            REG_CNEW_ZP:    prdata = {48'd0, r_cnew_zp};
            REG_CF_SCALE:   prdata = {26'd0, r_cf_scale};
            REG_IG_SCALE:   prdata = {26'd0, r_ig_scale};
            REG_ADD_FIRST:  prdata = {26'd0, r_add_first};
            REG_ADD_SECOND: prdata = {26'd0, r_add_second};
            REG_ADD_RESULT: prdata = {26'd0, r_add_result};
            default:        prdata = '0;
        endcase
    end

    // stage 1: gate offsets and small products
    always_comb begin
        logic signed [16:0] cdiff;
        logic signed [8:0]  fo;
        logic signed [8:0]  io;
        cdiff = 17'(i_c_old) - 17'(r_c_zp);
        fo    = $signed({1'b0, ~i_forget_gate[7], i_forget_gate[6:0]});
        io    = $signed({1'b0, ~i_input_gate[7], i_input_gate[6:0]});
        n1_cf = 26'(cdiff) * 26'(fo);
        n1_ig = 17'(io) * 17'(i_cand_gate);
    end

    // stage 2: multiply by Q31 multipliers
    always_comb begin
        n2_cf = r1_cf * mult_of(r_cf_scale);
        n2_ig = r1_ig * mult_of(r_ig_scale);
    end

    // stage 3: round, shift, offset, saturate
    always_comb begin
        n3_cf = sat_ofs(rnd_shift(t_wide'(r2_cf), shift_amt(r_cf_scale)), r_cnew_zp);
        n3_ig = sat_ofs(rnd_shift(t_wide'(r2_ig), shift_amt(r_ig_scale)), r_cnew_zp);
    end

    // stage 4: recenter and scale sum operands
    always_comb begin
        n4_a = (r3_cf - r_cnew_zp) * mult_of(r_add_first);
        n4_b = (r3_ig - r_cnew_zp) * mult_of(r_add_second);
    end

    // stage 5: apply left shift, round and shift right
    always_comb begin
        n5_ra = 69'(rnd_shift(t_wide'(r4_a) <<< SUM_PRESHIFT, shift_amt(r_add_first)));
        n5_rb = 69'(rnd_shift(t_wide'(r4_b) <<< SUM_PRESHIFT, shift_amt(r_add_second)));
    end

    // stage 6: sum
    assign n6_sum = 70'(r5_ra) + 70'(r5_rb);

    // stage 7: split product
    always_comb begin
        n7_lo = $signed({1'b0, r6_sum[SPLIT_W-1:0]}) * mult_of(r_add_result);
        n7_hi = $signed(r6_sum[69:SPLIT_W]) * mult_of(r_add_result);
    end

    // stage 8: combine partial products
    assign n8_p = (t_wide'(r7_hi) <<< SPLIT_W) + t_wide'(r7_lo);

    // stage 9: final requant
    assign n9_c_new = sat_ofs(rnd_shift(r8_p, shift_amt(r_add_result)), r_cnew_zp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], s_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cf  <= n1_cf;
        r1_ig  <= n1_ig;
        r2_cf  <= n2_cf;
        r2_ig  <= n2_ig;
        r3_cf  <= n3_cf;
        r3_ig  <= n3_ig;
        r4_a   <= n4_a;
        r4_b   <= n4_b;
        r5_ra  <= n5_ra;
        r5_rb  <= n5_rb;
        r6_sum <= n6_sum;
        r7_lo  <= n7_lo;
        r7_hi  <= n7_hi;
        r8_p   <= n8_p;
        if (r_vld[7]) begin
            r9_c_new <= n9_c_new;
        end
    end

    assign o_c_new_valid = r_vld[8];
    assign o_c_new       = r9_c_new;

    `LCSU_ASSERT_IMP(a_lat_fwd, s_acc, ##9 o_c_new_valid, "item lost in pipeline")
    `LCSU_ASSERT_IMP(a_lat_bwd, o_c_new_valid, $past(s_acc, 9), "result without item")
    `LCSU_ASSERT_NXT(a_czp_wr, cfg_wr && (paddr[5:3] == REG_C_ZP),
        $unsigned(r_c_zp) == $past(pwdata[15:0]), "zero point write lost")
    `LCSU_ASSERT_NXT(a_res_wr, cfg_wr && (paddr[5:3] == REG_ADD_RESULT),
        r_add_result == $past(pwdata[37:0]), "result scale write lost")

endmodule

`default_nettype wire
